// ----- src/lps_pkg.sv -----
// lps_pkg: shared types, constants and pattern tables for the led pattern sequencer
// used by lps_csr, lps_engine, the core top level and its checker
`timescale 1ns / 1ps

package lps_pkg;

   // field widths
   localparam int unsigned NUM_PATTERNS = 6;
   localparam int unsigned MAX_STEPS    = 6;
   localparam int unsigned PAT_W        = 3;
   localparam int unsigned STEP_W       = 3;
   localparam int unsigned TICK_W       = 4;
   localparam int unsigned HOLD_W       = 5;
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned LED_W        = 6;
   localparam int unsigned CSR_IDX_W    = 3;
   localparam int unsigned CSR_DATA_W   = 8;

   // default button hold time in ticks
   localparam int unsigned HOLD_TICKS_DEFAULT = 24;

   // register reset values
   localparam logic [BYTE_W-1:0] CODE_ONE_RESET    = 8'd49;
   localparam logic [TICK_W-1:0] SHORT_TICKS_RESET = 4'd3;
   localparam logic [TICK_W-1:0] LONG_TICKS_RESET  = 4'd10;

   // item kinds
   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_BYTE = 1'b1;

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CODE_ONE    = 3'd0,
      CSR_CODE_TWO    = 3'd1,
      CSR_CODE_THREE  = 3'd2,
      CSR_CODE_FOUR   = 3'd3,
      CSR_CODE_FIVE   = 3'd4,
      CSR_CODE_SIX    = 3'd5,
      CSR_SHORT_TICKS = 3'd6,
      CSR_LONG_TICKS  = 3'd7
   } csr_index_type;

   // pattern tables: step count, long step flag, led word per step
   localparam logic [STEP_W-1:0] PAT_LEN [NUM_PATTERNS] =
      '{3'd6, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3};
   localparam logic PAT_LONG [NUM_PATTERNS] =
      '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
   localparam logic [LED_W-1:0] PAT_LEDS [NUM_PATTERNS][MAX_STEPS] = '{
      '{6'h01, 6'h02, 6'h04, 6'h08, 6'h10, 6'h20},
      '{6'h3F, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
      '{6'h15, 6'h2A, 6'h00, 6'h00, 6'h00, 6'h00},
      '{6'h33, 6'h0C, 6'h00, 6'h00, 6'h00, 6'h00},
      '{6'h03, 6'h0C, 6'h30, 6'h00, 6'h00, 6'h00},
      '{6'h0C, 6'h12, 6'h21, 6'h00, 6'h00, 6'h00}
   };

   // configuration seen by the engine
   typedef struct packed {
      logic [NUM_PATTERNS-1:0][BYTE_W-1:0] codes;
      logic [TICK_W-1:0]                   short_ticks;
      logic [TICK_W-1:0]                   long_ticks;
   } csr_type;

   // one input item
   typedef struct packed {
      logic              mode;
      logic [BYTE_W-1:0] rx_byte;
      logic              framing_error;
      logic              overrun_error;
      logic              button_pressed;
   } item_type;

   // one result item
   typedef struct packed {
      logic [LED_W-1:0]  led_levels;
      logic              echo_valid;
      logic [BYTE_W-1:0] echo_byte;
      logic              reset_request;
   } result_type;

   // pattern codes six and seven fall back to pattern one
   function automatic logic [PAT_W-1:0] pat_index(input logic [PAT_W-1:0] p);
      return (p < PAT_W'(NUM_PATTERNS)) ? p : '0;
   endfunction

endpackage

// ----- src/lps_csr.sv -----
// lps_csr: configuration registers (pattern codes and step durations)
// depends on lps_pkg
`timescale 1ns / 1ps

module lps_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [lps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lps_pkg::CSR_DATA_W-1:0]     csr_data,
   output lps_pkg::csr_type                   csr_out
);

   logic [lps_pkg::NUM_PATTERNS-1:0][lps_pkg::BYTE_W-1:0] codes_ff;
   logic [lps_pkg::TICK_W-1:0]                            short_ff;
   logic [lps_pkg::TICK_W-1:0]                            long_ff;
   lps_pkg::csr_index_type                                idx;

   assign idx = lps_pkg::csr_index_type'(csr_index);

   // register writes, decoded by index
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lps_pkg::NUM_PATTERNS; i++) begin
            codes_ff[i] <= lps_pkg::CODE_ONE_RESET + lps_pkg::BYTE_W'(i);
         end
         short_ff <= lps_pkg::SHORT_TICKS_RESET;
         long_ff  <= lps_pkg::LONG_TICKS_RESET;
      end else if (csr_write) begin
         unique case (idx)
            lps_pkg::CSR_SHORT_TICKS: short_ff <= csr_data[lps_pkg::TICK_W-1:0];
            lps_pkg::CSR_LONG_TICKS:  long_ff  <= csr_data[lps_pkg::TICK_W-1:0];
            default: codes_ff[csr_index] <= csr_data;
         endcase
      end
   end

   assign csr_out.codes       = codes_ff;
   assign csr_out.short_ticks = short_ff;
   assign csr_out.long_ticks  = long_ff;

endmodule

// ----- src/lps_engine.sv -----
// lps_engine: sequencer state and the single-pass update for one item
// depends on lps_pkg
`timescale 1ns / 1ps

module lps_engine #(
   parameter int unsigned HOLD_TICKS = lps_pkg::HOLD_TICKS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  lps_pkg::item_type     item,
   input  lps_pkg::csr_type      csr,
   output lps_pkg::result_type   result
);

   localparam logic [lps_pkg::HOLD_W-1:0] HOLD_RELOAD = lps_pkg::HOLD_W'(HOLD_TICKS);

   logic [lps_pkg::PAT_W-1:0]  chosen_ff,  chosen_in;
   logic [lps_pkg::PAT_W-1:0]  running_ff, running_in;
   logic [lps_pkg::STEP_W-1:0] step_ff,    step_in;
   logic [lps_pkg::TICK_W-1:0] ticks_ff,   ticks_in;
   logic [lps_pkg::HOLD_W-1:0] hold_ff,    hold_in;

   logic [lps_pkg::STEP_W-1:0] step_plus;
   logic [lps_pkg::HOLD_W-1:0] hold_dec;
   logic [lps_pkg::PAT_W-1:0]  run_idx;
   logic [lps_pkg::STEP_W-1:0] led_step;
   logic                       req_reset;

   // next state and result for the item at the input register
   always_comb begin
      chosen_in  = chosen_ff;
      running_in = running_ff;
      step_in    = step_ff;
      ticks_in   = ticks_ff;
      hold_in    = hold_ff;
      step_plus  = step_ff + 1'b1;
      hold_dec   = hold_ff - 1'b1;
      req_reset  = 1'b0;
      result.echo_valid = 1'b0;
      result.echo_byte  = '0;

      if (item.mode == lps_pkg::MODE_TICK) begin
         // step timer
         if (ticks_ff <= lps_pkg::TICK_W'(1)) begin
            step_in = step_plus;
            if (step_plus >= lps_pkg::PAT_LEN[lps_pkg::pat_index(running_ff)]) begin
               step_in    = '0;
               running_in = lps_pkg::pat_index(chosen_ff);
            end
            ticks_in = lps_pkg::PAT_LONG[lps_pkg::pat_index(running_in)] ?
                       csr.long_ticks : csr.short_ticks;
         end else begin
            ticks_in = ticks_ff - 1'b1;
         end
         // button hold counter
         if (item.button_pressed) begin
            hold_in = hold_dec;
            if (hold_dec == '0) begin
               req_reset  = 1'b1;
               chosen_in  = '0;
               running_in = '0;
               step_in    = '0;
               ticks_in   = csr.short_ticks;
               hold_in    = HOLD_RELOAD;
            end
         end else begin
            hold_in = HOLD_RELOAD;
         end
      end else if (!item.framing_error && !item.overrun_error) begin
         // code match, lowest numbered pattern wins
         for (int i = lps_pkg::NUM_PATTERNS - 1; i >= 0; i--) begin
            if (csr.codes[i] == item.rx_byte) begin
               chosen_in = lps_pkg::PAT_W'(i);
            end
         end
         result.echo_valid = 1'b1;
         result.echo_byte  = item.rx_byte;
      end

      // led word of the current step after the update
      run_idx  = lps_pkg::pat_index(running_in);
      led_step = (step_in < lps_pkg::PAT_LEN[run_idx]) ? step_in : '0;
      result.led_levels    = lps_pkg::PAT_LEDS[run_idx][led_step];
      result.reset_request = req_reset;
   end

   // state registers advance once per processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         chosen_ff  <= '0;
         running_ff <= '0;
         step_ff    <= '0;
         ticks_ff   <= lps_pkg::SHORT_TICKS_RESET;
         hold_ff    <= HOLD_RELOAD;
      end else if (fire) begin
         chosen_ff  <= chosen_in;
         running_ff <= running_in;
         step_ff    <= step_in;
         ticks_ff   <= ticks_in;
         hold_ff    <= hold_in;
      end
   end

endmodule

// ----- src/led_pattern_sequencer_core.sv -----
// led_pattern_sequencer_core: top level with input register, engine and result register
// depends on lps_pkg, lps_csr, lps_engine
`timescale 1ns / 1ps

// Each accepted item (a timer tick or a received serial byte) gives exactly one result:
// the LED word of the current step, an echo of a good byte, and a reset request when the
// button has been held for HOLD_TICKS ticks. The block takes one item per clock cycle
// when rsp_stall is low; a result goes through the input register, then the result
// register, with the state update done in the single logic stage between them. A
// stalled result register holds the input register, which in turn raises req_stall.
// The user must write configuration registers only while idle; it is not enforced.

module led_pattern_sequencer_core #(
   parameter int unsigned HOLD_TICKS = lps_pkg::HOLD_TICKS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_mode,
   input  logic [lps_pkg::BYTE_W-1:0]        req_rx_byte,
   input  logic                              req_framing_error,
   input  logic                              req_overrun_error,
   input  logic                              req_button_pressed,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lps_pkg::LED_W-1:0]         rsp_led_levels,
   output logic                              rsp_echo_valid,
   output logic [lps_pkg::BYTE_W-1:0]        rsp_echo_byte,
   output logic                              rsp_reset_request,
   // configuration port
   input  logic                              csr_write,
   input  logic [lps_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lps_pkg::CSR_DATA_W-1:0]    csr_data
);

   logic                 in_valid_ff;
   lps_pkg::item_type    in_item_ff;
   logic                 out_valid_ff;
   lps_pkg::result_type  out_result_ff;
   lps_pkg::result_type  result;
   lps_pkg::csr_type     csr;
   logic                 out_free;
   logic                 fire;
   logic                 in_take;

   // pipeline control
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign in_take   = req_valid && !req_stall;

   lps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .csr_out   (csr)
   );

   lps_engine #(
      .HOLD_TICKS (HOLD_TICKS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_item_ff),
      .csr    (csr),
      .result (result)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_take || fire) begin
         in_valid_ff <= in_take;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_item_ff.mode           <= req_mode;
         in_item_ff.rx_byte        <= req_rx_byte;
         in_item_ff.framing_error  <= req_framing_error;
         in_item_ff.overrun_error  <= req_overrun_error;
         in_item_ff.button_pressed <= req_button_pressed;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_result_ff <= result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_led_levels    = out_result_ff.led_levels;
   assign rsp_echo_valid    = out_result_ff.echo_valid;
   assign rsp_echo_byte     = out_result_ff.echo_byte;
   assign rsp_reset_request = out_result_ff.reset_request;

endmodule

// ----- src/lps_checker.sv -----
// lps_checker: port-level assertions for the led pattern sequencer core, and its bind
// depends on lps_pkg and led_pattern_sequencer_core
`timescale 1ns / 1ps

module lps_assert (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [lps_pkg::LED_W-1:0]         rsp_led_levels,
   input  logic                              rsp_echo_valid,
   input  logic [lps_pkg::BYTE_W-1:0]        rsp_echo_byte,
   input  logic                              rsp_reset_request
);

   // a stalled request stays offered until its transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid)
      else $error("stalled request withdrawn");

   // a stalled result holds until its transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_led_levels)
         && $stable(rsp_echo_valid) && $stable(rsp_echo_byte)
         && $stable(rsp_reset_request))
      else $error("stalled result changed");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a reset request returns to pattern one, first step
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reset_request |-> rsp_led_levels == lps_pkg::PAT_LEDS[0][0])
      else $error("reset request without reset led word");

   // echo and reset request come from different item kinds; no echo means zero byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_echo_valid && rsp_reset_request)
         && (rsp_echo_valid || rsp_echo_byte == '0))
      else $error("inconsistent echo or reset request");

endmodule

bind led_pattern_sequencer_core lps_assert u_lps_assert (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_led_levels    (rsp_led_levels),
   .rsp_echo_valid    (rsp_echo_valid),
   .rsp_echo_byte     (rsp_echo_byte),
   .rsp_reset_request (rsp_reset_request)
);
